[hw/rtl/lphe_pkg.sv]
// Package for the lossless predictive Huffman encoder.
// Holds the channel payload types, the job passed from front to back and the fixed constants.
// No dependencies.
package lphe_pkg;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  localparam logic REG_ROW_PIXELS    = 1'b0;
  localparam logic REG_CHANNEL_COUNT = 1'b1;

  localparam int CAT_COUNT   = 17;
  localparam int CAT_TOP     = 16;
  localparam int CODE_W      = 16;
  localparam int WORD_W      = 32;
  localparam int NBITS_W     = 6;
  localparam int ACC_W       = 39;
  localparam int CNT_W       = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] sample;
    logic [4:0]  table_index;
    logic [15:0] code_word;
    logic [4:0]  code_length;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_t;

  typedef struct packed {
    logic [15:0] row_pixels;
    logic [2:0]  channel_count;
  } cfg_t;

  typedef struct packed {
    logic               flush;
    logic [WORD_W-1:0]  bits;
    logic [NBITS_W-1:0] nbits;
  } job_t;

endpackage

[hw/rtl/lphe_front.sv]
// Front end: accepts items, keeps the code table and image position, predicts and classifies.
// Emits one bit-string job per encode or finish into the queue.
// Depends on lphe_pkg.
module lphe_front import lphe_pkg::*; #(
  parameter int MAX_CHANNELS = 4,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_ready,
  input  in_t  item,
  input  cfg_t cfg,
  input  logic queue_full,
  output logic job_valid,
  output job_t job
);

  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [SAMPLE_BITS-1:0] left_sample      [MAX_CHANNELS];
  logic [SAMPLE_BITS-1:0] row_start_sample [MAX_CHANNELS];
  logic [CODE_W-1:0]      code_table       [CAT_COUNT];
  logic [4:0]             length_table     [CAT_COUNT];
  logic [15:0]            column_index;
  logic [CH_W-1:0]        channel_index;
  logic                   first_row;

  logic                   accept;
  logic [SAMPLE_BITS-1:0] val;
  logic [SAMPLE_BITS-1:0] pred;
  logic [16:0]            diff;
  logic [16:0]            mag;
  logic [16:0]            extra;
  logic [4:0]             cat;
  logic [15:0]            cat_mask;
  logic [CODE_W-1:0]      code;
  logic [4:0]             clen;
  logic [2:0]             chans;
  logic [15:0]            rows;
  logic                   last_chan;
  logic                   last_col;
  logic [4:0]             load_len;
  logic [15:0]            load_mask;

  assign item_ready = !queue_full;
  assign accept     = item_valid && item_ready;
  assign val        = item.sample[SAMPLE_BITS-1:0];

  always_comb begin
    if (column_index == 16'd0) begin
      pred = first_row ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : row_start_sample[channel_index];
    end else begin
      pred = left_sample[channel_index];
    end
  end

  assign diff  = 17'(val) - 17'(pred);
  assign mag   = diff[16] ? (~diff + 17'd1) : diff;
  assign extra = diff[16] ? (diff - 17'd1) : diff;

  always_comb begin
    cat = 5'd0;
    for (int i = 0; i < CAT_TOP; i++) begin
      if (mag[i]) begin
        cat = 5'(i + 1);
      end
    end
  end

  assign cat_mask = 16'((17'd1 << cat) - 17'd1);
  assign code     = code_table[cat];
  assign clen     = length_table[cat];

  always_comb begin
    if (cfg.channel_count == 3'd0) begin
      chans = 3'd1;
    end else if (cfg.channel_count > 3'(MAX_CHANNELS)) begin
      chans = 3'(MAX_CHANNELS);
    end else begin
      chans = cfg.channel_count;
    end
  end

  assign rows      = (cfg.row_pixels == 16'd0) ? 16'd1 : cfg.row_pixels;
  assign last_chan = (4'(channel_index) + 4'd1) >= 4'(chans);
  assign last_col  = (17'(column_index) + 17'd1) >= 17'(rows);

  assign load_len  = (item.code_length > 5'd16) ? 5'd16 : item.code_length;
  assign load_mask = 16'((17'd1 << load_len) - 17'd1);

  assign job_valid = accept && (item.opcode == OP_ENCODE || item.opcode == OP_FINISH);

  always_comb begin
    job.flush = (item.opcode == OP_FINISH);
    if (item.opcode == OP_ENCODE) begin
      job.bits  = (WORD_W'(code) << cat) | WORD_W'(extra[15:0] & cat_mask);
      job.nbits = NBITS_W'(clen) + NBITS_W'(cat);
    end else begin
      job.bits  = '0;
      job.nbits = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.opcode == OP_LOAD && item.table_index < 5'(CAT_COUNT)) begin
      length_table[item.table_index] <= load_len;
      code_table[item.table_index]   <= item.code_word & load_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        left_sample[i]      <= '0;
        row_start_sample[i] <= '0;
      end
      column_index  <= '0;
      channel_index <= '0;
      first_row     <= 1'b1;
    end else if (accept && item.opcode == OP_ENCODE) begin
      if (column_index == 16'd0) begin
        row_start_sample[channel_index] <= val;
      end
      left_sample[channel_index] <= val;
      if (last_chan) begin
        channel_index <= '0;
        if (last_col) begin
          column_index <= '0;
          first_row    <= 1'b0;
        end else begin
          column_index <= column_index + 16'd1;
        end
      end else begin
        channel_index <= channel_index + CH_W'(1);
      end
    end else if (accept && item.opcode == OP_FINISH) begin
      column_index  <= '0;
      channel_index <= '0;
      first_row     <= 1'b1;
    end
  end

endmodule

[hw/rtl/lphe_queue.sv]
// Short job queue between the front and back ends of the encoder.
// Register-based circular buffer with occupancy count.
// Depends on lphe_pkg.
module lphe_queue import lphe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

endmodule

[hw/rtl/lphe_back.sv]
// Back end: bit packer that merges jobs, emits bytes MSB first and stuffs zero after 0xFF.
// Drives the result channel from an output register.
// Depends on lphe_pkg.
module lphe_back import lphe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  input  job_t job,
  output logic job_ready,
  output logic result_valid,
  input  logic result_ready,
  output out_t result
);

  logic [ACC_W-1:0] acc;
  logic [CNT_W-1:0] cnt;
  logic             stuff;

  logic             out_free;
  logic             emit_data;
  logic             emit_stuff;
  logic [7:0]       data_byte;
  logic [CNT_W-1:0] cnt_after;
  logic             stuff_after;
  logic [14:0]      pad_word;
  logic [7:0]       pad_byte;
  logic [ACC_W-1:0] acc_merge;

  assign out_free   = !result_valid || result_ready;
  assign emit_stuff = stuff && out_free;
  assign emit_data  = !stuff && (cnt >= CNT_W'(8)) && out_free;
  assign data_byte  = 8'(acc >> (cnt - CNT_W'(8)));

  assign cnt_after   = emit_data ? (cnt - CNT_W'(8)) : cnt;
  assign stuff_after = emit_data ? (data_byte == 8'hFF) : (stuff && !emit_stuff);

  assign job_ready = job_valid && !stuff_after && (cnt_after < CNT_W'(8));

  assign pad_word  = {acc[6:0], 8'hFF} >> cnt_after[2:0];
  assign pad_byte  = pad_word[7:0];
  assign acc_merge = (ACC_W'(acc[6:0]) << job.nbits) | ACC_W'(job.bits);

  always_ff @(posedge clk) begin
    if (job_ready) begin
      if (job.flush) begin
        acc <= ACC_W'(pad_byte);
      end else begin
        acc <= acc_merge;
      end
    end
    if (emit_data) begin
      result.out_byte  <= data_byte;
      result.last_byte <= (cnt_after < CNT_W'(8)) && (data_byte != 8'hFF);
    end else if (emit_stuff) begin
      result.out_byte  <= 8'h00;
      result.last_byte <= (cnt < CNT_W'(8));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      stuff        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      stuff <= stuff_after;
      if (job_ready) begin
        if (job.flush) begin
          cnt <= (cnt_after != '0) ? CNT_W'(8) : '0;
        end else begin
          cnt <= cnt_after + CNT_W'(job.nbits);
        end
      end else begin
        cnt <= cnt_after;
      end
      if (emit_data || emit_stuff) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/lossless_predictive_huffman_encoder.sv]
// Lossless predictive Huffman encoder, top level with APB register block.
// The first byte of an item goes through the job queue, the packer accumulator and the output register.
// The input takes one item per cycle while the 4-entry job queue has room;
// the packer emits one byte per cycle while the result channel is ready, and takes a job once under a byte is left.
// Reset clears position, predictors, packer and queue; the code table is undefined until loaded.
// Depends on lphe_pkg, lphe_front, lphe_queue and lphe_back.
module lossless_predictive_huffman_encoder import lphe_pkg::*; #(
  parameter int MAX_CHANNELS = 4,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  in_t         item,
  output logic        result_valid,
  input  logic        result_ready,
  output out_t        result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  logic push;
  job_t push_job;
  logic full;
  logic pop;
  logic head_valid;
  job_t head_job;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_pixels    <= 16'd1;
      cfg.channel_count <= 3'd1;
    end else if (wr_en) begin
      case (paddr[2])
        REG_ROW_PIXELS:    cfg.row_pixels    <= pwdata[15:0];
        REG_CHANNEL_COUNT: cfg.channel_count <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ROW_PIXELS:    prdata = 32'(cfg.row_pixels);
      REG_CHANNEL_COUNT: prdata = 32'(cfg.channel_count);
      default:           prdata = '0;
    endcase
  end

  lphe_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cfg        (cfg),
    .queue_full (full),
    .job_valid  (push),
    .job        (push_job)
  );

  lphe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  lphe_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (head_valid),
    .job          (head_job),
    .job_ready    (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
